// ----- rtl/ams_pkg.sv -----
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types for the accumulator machine: opcodes, sequencer states and the
// control beat of the multiply/divide unit.
// ----------------------------------------------------------------------------
package ams_pkg;

	typedef enum logic [3:0] {
		OP_SHOW   = 4'd0,
		OP_LOAD   = 4'd1,
		OP_JOIN   = 4'd2,
		OP_SAVE   = 4'd3,
		OP_CLEAR  = 4'd4,
		OP_JZERO  = 4'd5,
		OP_JNEG   = 4'd6,
		OP_JUMP   = 4'd7,
		OP_JPOS   = 4'd8,
		OP_ADD    = 4'd9,
		OP_SUB    = 4'd10,
		OP_MUL    = 4'd11,
		OP_DIV    = 4'd12
	} instr_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_OPER,
		S_MDIV
	} state_t;

	// start request to the multiply/divide unit
	typedef struct packed {
		logic go;
		logic div;
	} md_ctl_t;

endpackage

// ----- rtl/ams_muldiv.sv -----
// ----------------------------------------------------------------------------
// ams_muldiv
// Iterative multiply (shift-add) and signed divide (restoring, on magnitudes),
// one bit per cycle.
// ----------------------------------------------------------------------------
module ams_muldiv #(
	parameter int DW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ams_pkg::md_ctl_t   ctl,
	input  logic [DW-1:0]      a,
	input  logic [DW-1:0]      b,
	output logic               done,
	output logic [DW-1:0]      result
);

	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          div_q;
	logic          neg_q;
	logic [DW-1:0] opa_q;   // multiplicand / divisor
	logic [DW-1:0] opb_q;   // multiplier / dividend-quotient
	logic [DW-1:0] acc_q;   // product / remainder

	logic [DW-1:0] mag_a;
	logic [DW-1:0] mag_b;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;

	assign mag_a   = a[DW-1] ? (~a + DW'(1)) : a;
	assign mag_b   = b[DW-1] ? (~b + DW'(1)) : b;
	assign shifted = {acc_q, opb_q[DW-1]};
	assign diff    = shifted - {1'b0, opa_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !ctl.go && (cnt_q == CW'(1));
			if (ctl.go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			div_q <= ctl.div;
			neg_q <= a[DW-1] ^ b[DW-1];
			acc_q <= '0;
			if (ctl.div) begin
				opa_q <= mag_b;
				opb_q <= mag_a;
			end else begin
				opa_q <= a;
				opb_q <= b;
			end
		end else if (run_q) begin
			if (div_q) begin
				if (!diff[DW]) begin
					acc_q <= diff[DW-1:0];
				end else begin
					acc_q <= shifted[DW-1:0];
				end
				opb_q <= {opb_q[DW-2:0], ~diff[DW]};
			end else begin
				if (opb_q[0]) begin
					acc_q <= acc_q + opa_q;
				end
				opa_q <= {opa_q[DW-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[DW-1:1]};
			end
		end
	end

	assign done = done_q;

	always_comb begin
		if (div_q) begin
			result = neg_q ? (~opb_q + DW'(1)) : opb_q;
		end else begin
			result = acc_q;
		end
	end

endmodule

// ----- rtl/accumulator_machine_step.sv -----
// ----------------------------------------------------------------------------
// accumulator_machine_step
// One-accumulator machine: a write beat loads one memory word, a step beat
// fetches and executes the instruction at the program counter.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload
//  -------   ---------------  ---------------------------------------------
//  item in   start / busy     op, write_address, write_word
//  result    done (strobe)    print_valid, print_value, halted, divide_error
//
// A write beat or a step while halted gives its result in the cycle after
// acceptance. A step runs fetch read, operand read and execute in turn
// through the single-read-port memory; multiply and divide then go on in
// the bit-serial unit before the result is given.
// busy is high from acceptance until the cycle done is shown; a new beat can
// be accepted in the done cycle. The result receiver cannot stall.
// Reset clears accumulator, program counter and halt flag; memory contents
// are undefined until written, and no clearing pass runs.
// Instruction: opcode in the top four data bits, signed operand in bits 9..0,
// operand low nine bits used as address. Addresses at or above MEM_DEPTH read
// as zero and drop writes.
// ----------------------------------------------------------------------------
module accumulator_machine_step #(
	parameter int MEM_DEPTH  = 512,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [8:0]         write_address,
	input  logic signed [31:0] write_word,
	output logic               done,
	output logic               print_valid,
	output logic signed [31:0] print_value,
	output logic               halted,
	output logic               divide_error
);

	localparam int          AW        = $clog2(MEM_DEPTH);
	localparam logic [9:0]  DEPTH_LIM = 10'(MEM_DEPTH);

	// address 0..511 is inside the memory when below MEM_DEPTH
	function automatic logic in_mem(input logic [8:0] addr);
		return {1'b0, addr} < DEPTH_LIM;
	endfunction

	ams_pkg::state_t state_q, state_d;

	logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [AW-1:0]         mem_raddr;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;

	logic [DATA_WIDTH-1:0] acc_q;
	logic [8:0]            pc_q;
	logic                  stopped_q;
	logic                  done_q;
	logic                  print_valid_q;
	logic signed [31:0]    print_value_q;
	logic                  divide_error_q;
	logic                  fetch_ok_q;
	logic                  oper_ok_q;
	logic [DATA_WIDTH-1:0] instr_q;

	logic                  accept;
	logic [DATA_WIDTH-1:0] fetch_word;
	logic [DATA_WIDTH-1:0] oper_data;
	ams_pkg::instr_op_t    opc;
	logic [8:0]            oper_addr;
	logic                  take;
	logic                  acc_zero;
	logic                  acc_neg;

	ams_pkg::md_ctl_t      md_ctl;
	logic                  md_done;
	logic [DATA_WIDTH-1:0] md_result;

	assign accept     = start && !busy;
	assign fetch_word = fetch_ok_q ? rd_data_q : '0;
	assign oper_data  = oper_ok_q ? rd_data_q : '0;
	assign opc        = ams_pkg::instr_op_t'(instr_q[DATA_WIDTH-1 -: 4]);
	assign oper_addr  = instr_q[8:0];
	assign acc_zero   = (acc_q == '0);
	assign acc_neg    = acc_q[DATA_WIDTH-1];

	always_comb begin
		case (opc)
			ams_pkg::OP_JZERO: take = acc_zero;
			ams_pkg::OP_JNEG:  take = acc_neg;
			ams_pkg::OP_JPOS:  take = !acc_zero && !acc_neg;
			ams_pkg::OP_JUMP:  take = 1'b1;
			default:           take = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ams_pkg::S_IDLE: begin
				if (accept && op && !stopped_q) begin
					state_d = ams_pkg::S_FETCH;
				end
			end
			ams_pkg::S_FETCH: state_d = ams_pkg::S_OPER;
			ams_pkg::S_OPER: begin
				if (opc == ams_pkg::OP_MUL ||
				    (opc == ams_pkg::OP_DIV && oper_data != '0)) begin
					state_d = ams_pkg::S_MDIV;
				end else begin
					state_d = ams_pkg::S_IDLE;
				end
			end
			ams_pkg::S_MDIV: begin
				if (md_done) begin
					state_d = ams_pkg::S_IDLE;
				end
			end
			default: state_d = ams_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy       = 1'b1;
		mem_raddr  = pc_q[AW-1:0];
		mem_we     = 1'b0;
		mem_waddr  = write_address[AW-1:0];
		mem_wdata  = write_word[DATA_WIDTH-1:0];
		md_ctl.go  = 1'b0;
		md_ctl.div = 1'b0;
		case (state_q)
			ams_pkg::S_IDLE: begin
				busy   = 1'b0;
				mem_we = accept && !op && in_mem(write_address);
			end
			ams_pkg::S_FETCH: begin
				mem_raddr = fetch_word[AW-1:0];
			end
			ams_pkg::S_OPER: begin
				mem_waddr  = oper_addr[AW-1:0];
				mem_wdata  = acc_q;
				mem_we     = (opc == ams_pkg::OP_SAVE) && in_mem(oper_addr);
				md_ctl.div = (opc == ams_pkg::OP_DIV);
				md_ctl.go  = (opc == ams_pkg::OP_MUL) ||
				             (opc == ams_pkg::OP_DIV && oper_data != '0);
			end
			default: ;
		endcase
	end

	// data memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ams_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			pc_q           <= '0;
			stopped_q      <= 1'b0;
			done_q         <= 1'b0;
			print_valid_q  <= 1'b0;
			divide_error_q <= 1'b0;
			fetch_ok_q     <= 1'b0;
			oper_ok_q      <= 1'b0;
		end else begin
			// write beat or step while halted answers at once; a step answers
			// after execute unless the multiply/divide unit takes over
			done_q         <= (state_q == ams_pkg::S_IDLE && accept && (!op || stopped_q)) ||
			                  (state_q == ams_pkg::S_OPER && !md_ctl.go) ||
			                  (state_q == ams_pkg::S_MDIV && md_done);
			print_valid_q  <= (state_q == ams_pkg::S_OPER) && (opc == ams_pkg::OP_SHOW);
			divide_error_q <= (state_q == ams_pkg::S_OPER) && (opc == ams_pkg::OP_DIV) &&
			                  (oper_data == '0);
			case (state_q)
				ams_pkg::S_IDLE: begin
					fetch_ok_q <= in_mem(pc_q);
				end
				ams_pkg::S_FETCH: begin
					pc_q      <= pc_q + 9'd1;
					oper_ok_q <= in_mem(fetch_word[8:0]);
				end
				ams_pkg::S_OPER: begin
					case (opc)
						ams_pkg::OP_LOAD:  acc_q <= oper_data;
						ams_pkg::OP_CLEAR: acc_q <= '0;
						ams_pkg::OP_ADD:   acc_q <= acc_q + oper_data;
						ams_pkg::OP_SUB:   acc_q <= acc_q - oper_data;
						default: ;
					endcase
					if (take) begin
						if (instr_q[9]) begin
							stopped_q <= 1'b1;
						end else begin
							pc_q <= oper_addr;
						end
					end
				end
				ams_pkg::S_MDIV: begin
					if (md_done) begin
						acc_q <= md_result;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ams_pkg::S_FETCH) begin
			instr_q <= fetch_word;
		end
		if (state_q == ams_pkg::S_OPER && opc == ams_pkg::OP_SHOW) begin
			print_value_q <= 32'(signed'(oper_data));
		end
	end

	ams_muldiv #(
		.DW(DATA_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md_ctl),
		.a      (acc_q),
		.b      (oper_data),
		.done   (md_done),
		.result (md_result)
	);

	assign done         = done_q;
	assign print_valid  = print_valid_q;
	assign print_value  = print_valid_q ? print_value_q : 32'sd0;
	assign halted       = stopped_q;
	assign divide_error = divide_error_q;

`ifndef NO_ASSERTIONS
	// a result only follows an accepted beat or a step in progress
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != ams_pkg::S_IDLE || accept))
		else $error("result strobe without a beat in flight");

	// halt is sticky until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("halt flag dropped");

	// step while halted answers next cycle with nothing but halted
	a_halted_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op && stopped_q) |=> (done && halted && !print_valid && !divide_error))
		else $error("step while halted misbehaved");

	// status flags only show with the strobe
	a_flags_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(print_valid || divide_error) |-> done)
		else $error("status flag outside result cycle");
`endif

endmodule

// ----- tb/sv/accumulator_machine_step_tb.sv -----
// ----------------------------------------------------------------------------
// accumulator_machine_step_tb
// Self-checking bench for the accumulator machine. A scoreboard class keeps
// its own copy of memory, accumulator, program counter and halt flag. It
// predicts every result beat from the accepted command beats and compares the
// strobed results in order. Stimulus is a short directed program, then random
// programs with random data. Guarded steps never fetch or read an unwritten
// word and never halt early. The run ends with a deliberate halt.
// ----------------------------------------------------------------------------
module accumulator_machine_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 250_000;
	localparam int TAIL_CYCLES = 80;
	localparam int RANDOM_BEATS = 900;

	// one result beat, as the block shows it
	typedef struct packed {
		logic        pv;
		logic [31:0] val;
		logic        halt;
		logic        derr;
	} machine_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: machine state mirror plus queue of expected result beats
	// ------------------------------------------------------------------------
	class machine_scoreboard;
		logic [31:0]     mem [512];
		bit              written [512];
		logic [31:0]     acc;
		logic [8:0]      pc;
		bit              stopped;
		machine_result_t pending_q [$];
		int              fails;

		// branch condition on the current accumulator; sign of target ignored
		function bit jump_taken(logic [3:0] opc);
			case (opc)
				ams_pkg::OP_JZERO: return acc == 32'd0;
				ams_pkg::OP_JNEG:  return acc[31];
				ams_pkg::OP_JPOS:  return acc != 32'd0 && !acc[31];
				ams_pkg::OP_JUMP:  return 1'b1;
				default:           return 1'b0;
			endcase
		endfunction

		// accepted command beat: advance the mirror, queue what it yields
		function void note_beat(logic is_step, logic [8:0] waddr, logic [31:0] wword);
			machine_result_t r;
			logic [31:0]     w;
			logic [31:0]     m;
			logic [31:0]     ma;
			logic [31:0]     mb;
			logic [31:0]     q;
			logic [3:0]      opc;
			logic [8:0]      a;
			r = '0;
			if (!is_step) begin
				mem[waddr] = wword;
				written[waddr] = 1'b1;
			end else if (!stopped) begin
				w = mem[pc];
				opc = w[31:28];
				a = w[8:0];
				m = mem[a];
				pc = pc + 9'd1;
				case (opc)
					ams_pkg::OP_SHOW: begin
						r.pv = 1'b1;
						r.val = m;
					end
					ams_pkg::OP_LOAD:  acc = m;
					ams_pkg::OP_SAVE: begin
						mem[a] = acc;
						written[a] = 1'b1;
					end
					ams_pkg::OP_CLEAR: acc = 32'd0;
					ams_pkg::OP_ADD:   acc = acc + m;
					ams_pkg::OP_SUB:   acc = acc - m;
					ams_pkg::OP_MUL:   acc = acc * m;
					ams_pkg::OP_DIV: begin
						if (m == 32'd0) begin
							r.derr = 1'b1;
						end else begin
							// sign-magnitude divide, truncates toward zero
							ma = acc[31] ? -acc : acc;
							mb = m[31] ? -m : m;
							q = ma / mb;
							if (acc[31] ^ m[31])
								q = -q;
							acc = q;
						end
					end
					default: ;
				endcase
				// jumps leave acc alone, so testing after the case is safe
				if (jump_taken(opc)) begin
					if (w[9])
						stopped = 1'b1;
					else
						pc = a;
				end
			end
			r.halt = stopped;
			pending_q.push_back(r);
		endfunction

		function void check_result(logic pv, logic [31:0] val, logic halt, logic derr);
			machine_result_t want;
			if (pending_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result beat: print_valid %0b print_value %0d",
						pv, $signed(val));
				return;
			end
			want = pending_q.pop_front();
			if (pv !== want.pv || val !== want.val || halt !== want.halt ||
					derr !== want.derr) begin
				fails++;
				if (fails <= 10)
					$display({"result mismatch: print_valid %0b/%0b print_value %0d/%0d",
						" halted %0b/%0b divide_error %0b/%0b (exp/got)"},
						want.pv, pv, $signed(want.val), $signed(val),
						want.halt, halt, want.derr, derr);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup; every input known from time zero
	// ------------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               op = 1'b0;
	logic [8:0]         write_address = '0;
	logic signed [31:0] write_word = '0;
	logic               done;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic               halted;
	logic               divide_error;

	machine_scoreboard sb = new;
	int                burst_left = 0;
	int                beats_sent = 0;
	int                cycle_count = 0;

	accumulator_machine_step u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.write_address (write_address),
		.write_word    (write_word),
		.done          (done),
		.print_valid   (print_valid),
		.print_value   (print_value),
		.halted        (halted),
		.divide_error  (divide_error)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("accumulator_machine_step_tb: errors");
			$finish;
		end
	end

	// Result side: done is a one-cycle strobe, sampled at the edge closing it.
	// The receiver has no way to stall, so there is nothing to throttle here.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(print_valid, print_value, halted, divide_error);
	end

	// ------------------------------------------------------------------------
	// Command side. All tasks start and end on a rising edge and touch start
	// once per edge, so a back-to-back beat keeps start high without a glitch.
	// ------------------------------------------------------------------------
	task automatic idle(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// One command beat, sent in bursts with random gaps between bursts.
	// Some bursts are long so stretches with no gaps occur too.
	task automatic push_beat(logic is_step, logic [8:0] waddr, logic [31:0] wword);
		if (burst_left == 0) begin
			idle($urandom_range(1, 9));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		op <= is_step;
		write_address <= waddr;
		write_word <= wword;
		// accepted at the first edge that sees busy low
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_beat(is_step, waddr, wword);
		beats_sent++;
	endtask

	task automatic poke_word(logic [8:0] addr, logic [31:0] w);
		push_beat(1'b0, addr, w);
	endtask

	// hold off until every outstanding result beat has come back
	task automatic drain();
		idle(1);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] encode(logic [3:0] opc, logic [9:0] operand);
		return {opc, 18'd0, operand};
	endfunction

	// data mix: corner values often, small numbers for mul/div, full random
	function automatic logic [31:0] rand_data();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'h8000_0000;
			2:       return 32'h7fff_ffff;
			3:       return 32'hffff_ffff;
			4, 5:    return 32'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	// Random instruction. Jumps aim into [lo, lo+span), memory operands into an
	// 8-word data block at dbase. Negative operands show up now and then;
	// filler bits 27..10 are random since the block should ignore them.
	function automatic logic [31:0] rand_instr(logic [8:0] lo, int span, logic [8:0] dbase);
		logic [31:0] w;
		w = $urandom;
		w[31:28] = 4'($urandom_range(0, 15));
		if (w[31:28] inside {ams_pkg::OP_JZERO, ams_pkg::OP_JNEG, ams_pkg::OP_JUMP,
				ams_pkg::OP_JPOS}) begin
			w[9] = ($urandom_range(0, 5) == 0);
			w[8:0] = lo + 9'($urandom_range(0, span - 1));
		end else if (w[31:28] inside {ams_pkg::OP_SHOW, ams_pkg::OP_LOAD, ams_pkg::OP_SAVE,
				ams_pkg::OP_ADD, ams_pkg::OP_SUB, ams_pkg::OP_MUL, ams_pkg::OP_DIV}) begin
			w[9] = ($urandom_range(0, 7) == 0);
			w[8:0] = dbase + 9'($urandom_range(0, 7));
		end
		return w;
	endfunction

	// Guarded step: the mirror knows pc and memory, so patch things first so
	// the step never fetches or reads an unwritten word and never halts.
	task automatic exec_step();
		logic [31:0] w;
		if (!sb.written[sb.pc])
			poke_word(sb.pc, rand_instr(sb.pc, 8, sb.pc + 9'd16));
		w = sb.mem[sb.pc];
		if (w[9] && sb.jump_taken(w[31:28])) begin
			do
				w = rand_instr(sb.pc, 8, sb.pc + 9'd16);
			while (w[9] && sb.jump_taken(w[31:28]));
			poke_word(sb.pc, w);
		end
		if (w[31:28] inside {ams_pkg::OP_SHOW, ams_pkg::OP_LOAD, ams_pkg::OP_ADD,
				ams_pkg::OP_SUB, ams_pkg::OP_MUL, ams_pkg::OP_DIV} &&
				!sb.written[w[8:0]])
			poke_word(w[8:0], rand_data());
		// address and word are don't-care on a step; keep them toggling
		push_beat(1'b1, 9'($urandom), $urandom);
	endtask

	// short random program at the current pc, a few data words, then steps
	task automatic run_program();
		int         len;
		int         nd;
		int         nsteps;
		logic [8:0] base;
		logic [8:0] dbase;
		len = $urandom_range(3, 12);
		dbase = 9'($urandom);
		base = sb.pc;
		for (int i = 0; i < len; i++)
			poke_word(base + 9'(i), rand_instr(base, len, dbase));
		nd = $urandom_range(2, 8);
		for (int j = 0; j < nd; j++)
			poke_word(dbase + 9'(j), rand_data());
		nsteps = $urandom_range(len, 3 * len);
		repeat (nsteps) begin
			// stray write in the middle of a run now and then
			if ($urandom_range(0, 11) == 0)
				poke_word(9'($urandom), $urandom);
			exec_step();
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		bit drained_mid;
		drained_mid = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed program: divide overflow (min / -1), divide by zero,
		// wrapping add and multiply, a far taken jump, a negative operand used
		// as an address, and the pc wrapping from 511 back to 0.
		poke_word(9'd500, 32'h8000_0000);
		poke_word(9'd501, 32'hffff_ffff);
		poke_word(9'd502, 32'h0000_0000);
		poke_word(9'd503, 32'h7fff_ffff);
		poke_word(9'd0, encode(ams_pkg::OP_LOAD, 10'd500));
		poke_word(9'd1, encode(ams_pkg::OP_DIV, 10'd501));
		poke_word(9'd2, encode(ams_pkg::OP_DIV, 10'd502));
		poke_word(9'd3, encode(ams_pkg::OP_ADD, 10'd503));
		poke_word(9'd4, encode(ams_pkg::OP_MUL, 10'd501));
		poke_word(9'd5, encode(ams_pkg::OP_JPOS, 10'd510));
		poke_word(9'd510, encode(ams_pkg::OP_SHOW, 10'h3f4)); // -12 -> address 500
		poke_word(9'd511, encode(ams_pkg::OP_SAVE, 10'd504));
		repeat (9) exec_step();

		// Random programs, with a few bursts of pure write noise
		while (beats_sent < RANDOM_BEATS) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					poke_word(9'($urandom), $urandom);
			end else begin
				run_program();
			end
			// let the pipe run dry once midway, and now and then later
			if ((!drained_mid && beats_sent > RANDOM_BEATS / 2) ||
					$urandom_range(0, 19) == 0) begin
				drain();
				drained_mid = 1'b1;
			end
		end

		// Halt last, since only reset clears it: a taken negative jump, then
		// a step and a write while halted, then one more step.
		drain();
		poke_word(sb.pc, encode(ams_pkg::OP_JUMP, 10'h3ff));
		push_beat(1'b1, 9'($urandom), $urandom);
		push_beat(1'b1, 9'($urandom), $urandom);
		poke_word(9'($urandom), $urandom);
		push_beat(1'b1, 9'($urandom), $urandom);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.pending_q.size() == 0)
			$display("accumulator_machine_step_tb: clean");
		else
			$display("accumulator_machine_step_tb: errors");
		$finish;
	end

endmodule
